@@ sv/ffba_pkg.sv @@
// types and constants shared by the first-fit allocator modules
// controller/datapath command and status structs, opcodes, response kinds
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 17;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_RESIZE = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POOL_BASE = 1'b0,
      CSR_POOL_SIZE = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      RSP_FAIL = 2'd0,
      RSP_OK   = 2'd1,
      RSP_BASE = 2'd2,
      RSP_FIT  = 2'd3
   } rsp_kind_type;

   typedef struct packed {
      logic         latch;
      logic         clear;
      logic         walk_reset;
      logic         walk_step;
      logic         save_old;
      logic         remove;
      logic         insert_new;
      logic         insert_old;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       present;
      logic       size_zero;
      logic       size_over;
      logic       full;
      logic       walk_end;
      logic       hit;
      logic       fit;
      logic       tail_fit;
      logic       out_free;
   } status_type;

endpackage

`default_nettype wire

@@ sv/ffba_ctrl.sv @@
// sequencer of the first-fit allocator: decode, table walks, response
// uses ffba_pkg; drives the datapath through cmd_type, reads status_type
`timescale 1ns / 1ps
`default_nettype none

module ffba_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire ffba_pkg::status_type sts,
   output ffba_pkg::cmd_type        cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECODE = 5'b00010,
      ST_FIND   = 5'b00100,
      ST_FIT    = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   ffba_pkg::rsp_kind_type kind_ff, kind_in;
   logic                   moving;

   // a resize of a present block that was lifted out and must go back on failure
   assign moving = (sts.op == ffba_pkg::OP_RESIZE) && sts.present;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      cmd.rsp_kind = kind_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.walk_reset = 1'b1;
            case (sts.op)
               ffba_pkg::OP_CLEAR: begin
                  cmd.clear = 1'b1;
                  kind_in   = ffba_pkg::RSP_OK;
                  state_in  = ST_RESP;
               end
               ffba_pkg::OP_ALLOC: state_in = ST_FIT;
               ffba_pkg::OP_FREE: begin
                  if (sts.present) begin
                     state_in = ST_FIND;
                  end else begin
                     kind_in  = ffba_pkg::RSP_FAIL;
                     state_in = ST_RESP;
                  end
               end
               ffba_pkg::OP_RESIZE: state_in = sts.present ? ST_FIND : ST_FIT;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_FIND: begin
            if (sts.walk_end) begin
               kind_in  = ffba_pkg::RSP_FAIL;
               state_in = ST_RESP;
            end else if (sts.hit) begin
               cmd.remove = 1'b1;
               if (sts.op == ffba_pkg::OP_FREE) begin
                  kind_in  = ffba_pkg::RSP_OK;
                  state_in = ST_RESP;
               end else if (sts.size_zero) begin
                  kind_in  = ffba_pkg::RSP_FAIL;
                  state_in = ST_RESP;
               end else begin
                  cmd.save_old   = 1'b1;
                  cmd.walk_reset = 1'b1;
                  state_in       = ST_FIT;
               end
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_FIT: begin
            if (sts.size_over) begin
               cmd.insert_old = moving;
               kind_in        = ffba_pkg::RSP_FAIL;
               state_in       = ST_RESP;
            end else if (sts.size_zero) begin
               kind_in  = ffba_pkg::RSP_BASE;
               state_in = ST_RESP;
            end else if (sts.full) begin
               kind_in  = ffba_pkg::RSP_FAIL;
               state_in = ST_RESP;
            end else if (sts.walk_end) begin
               state_in = ST_RESP;
               if (sts.tail_fit) begin
                  cmd.insert_new = 1'b1;
                  kind_in        = ffba_pkg::RSP_FIT;
               end else begin
                  cmd.insert_old = moving;
                  kind_in        = ffba_pkg::RSP_FAIL;
               end
            end else if (sts.fit) begin
               cmd.insert_new = 1'b1;
               kind_in        = ffba_pkg::RSP_FIT;
               state_in       = ST_RESP;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_RESP: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= ffba_pkg::RSP_FAIL;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/ffba_datapath.sv @@
// datapath of the first-fit allocator: block table, walk cursor, output stage
// uses ffba_pkg; commanded by ffba_ctrl
`timescale 1ns / 1ps
`default_nettype none

module ffba_datapath #(
   parameter int MAX_BLOCKS  = 16,
   parameter int OFFSET_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [ffba_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  wire logic [ffba_pkg::ADDR_W-1:0]       csr_wdata,
   input  wire logic [ffba_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [ffba_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [ffba_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire ffba_pkg::cmd_type                 cmd,
   output ffba_pkg::status_type                   sts
);

   localparam int OW   = OFFSET_BITS + 1;
   localparam int CW   = (OW > ffba_pkg::SIZE_W) ? OW : ffba_pkg::SIZE_W;
   localparam int AW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNTW = $clog2(MAX_BLOCKS + 1);
   localparam logic [CW-1:0] OMASK = {CW{1'b1}} >> (CW - OW);

   // table
   logic [OW-1:0]   start_ff [MAX_BLOCKS];
   logic [OW-1:0]   start_in [MAX_BLOCKS];
   logic [OW-1:0]   end_ff   [MAX_BLOCKS];
   logic [OW-1:0]   end_in   [MAX_BLOCKS];
   logic [CNTW-1:0] count_ff, count_in;

   // request and config
   logic [ffba_pkg::ADDR_W-1:0] base_ff;
   logic [OW-1:0]               psize_ff;
   ffba_pkg::opcode_type        op_ff;
   logic                        present_ff;
   logic [ffba_pkg::ADDR_W-1:0] addr_ff;
   logic [ffba_pkg::SIZE_W-1:0] size_ff;

   // walk
   logic [CNTW-1:0] i_ff, idx_ff;
   logic [OW-1:0]   cursor_ff;
   logic [OW-1:0]   old_s_ff, old_e_ff;

   // output stage
   logic                        rsp_valid_ff;
   logic                        ok_ff;
   logic [ffba_pkg::ADDR_W-1:0] res_ff;
   logic [ffba_pkg::SIZE_W-1:0] copy_ff;

   logic [OW-1:0]   rd_start, rd_end;
   logic [CW-1:0]   size_c, start_c, cursor_c, psize_c, old_c, copy_c;
   logic [CNTW-1:0] ins_pos;
   logic [OW-1:0]   ins_s, ins_e;
   logic            do_insert;

   assign rd_start = start_ff[i_ff[AW-1:0]];
   assign rd_end   = end_ff[i_ff[AW-1:0]];

   assign size_c   = CW'(size_ff) & OMASK;
   assign start_c  = CW'(rd_start);
   assign cursor_c = CW'(cursor_ff);
   assign psize_c  = CW'(psize_ff);
   assign old_c    = CW'(old_e_ff - old_s_ff);
   assign copy_c   = (size_c < old_c) ? size_c : old_c;

   always_comb begin
      sts.op        = op_ff;
      sts.present   = present_ff;
      sts.size_zero = (size_c == '0);
      sts.size_over = (size_c > psize_c);
      sts.full      = (count_ff == CNTW'(MAX_BLOCKS));
      sts.walk_end  = (i_ff == count_ff);
      sts.hit       = ((base_ff + ffba_pkg::ADDR_W'(rd_start)) == addr_ff);
      sts.fit       = (start_c >= cursor_c) && ((start_c - cursor_c) >= size_c);
      sts.tail_fit  = (psize_c >= cursor_c) && ((psize_c - cursor_c) >= size_c);
      sts.out_free  = !rsp_valid_ff || rsp_tready;
   end

   // parallel shift of the table on insert or remove
   assign do_insert = cmd.insert_new || cmd.insert_old;
   assign ins_pos   = cmd.insert_old ? idx_ff : i_ff;
   assign ins_s     = cmd.insert_old ? old_s_ff : cursor_ff;
   assign ins_e     = cmd.insert_old ? old_e_ff : OW'(cursor_c + size_c);

   always_comb begin
      for (int k = 0; k < MAX_BLOCKS; k++) begin
         start_in[k] = start_ff[k];
         end_in[k]   = end_ff[k];
         if (do_insert) begin
            if (CNTW'(k) == ins_pos) begin
               start_in[k] = ins_s;
               end_in[k]   = ins_e;
            end else if ((k > 0) && (CNTW'(k) > ins_pos)) begin
               start_in[k] = start_ff[(k > 0) ? k - 1 : 0];
               end_in[k]   = end_ff[(k > 0) ? k - 1 : 0];
            end
         end else if (cmd.remove) begin
            if ((k < MAX_BLOCKS - 1) && (CNTW'(k) >= i_ff)) begin
               start_in[k] = start_ff[(k < MAX_BLOCKS - 1) ? k + 1 : k];
               end_in[k]   = end_ff[(k < MAX_BLOCKS - 1) ? k + 1 : k];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (do_insert) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.remove) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_BLOCKS; k++) begin
         start_ff[k] <= start_in[k];
         end_ff[k]   <= end_in[k];
      end
      if (cmd.latch) begin
         op_ff      <= ffba_pkg::opcode_type'(req_tuser[1:0]);
         present_ff <= req_tuser[2];
         addr_ff    <= req_tdata[31:0];
         size_ff    <= req_tdata[48:32];
      end
      if (cmd.walk_reset) begin
         i_ff      <= '0;
         cursor_ff <= '0;
      end else if (cmd.walk_step) begin
         i_ff      <= i_ff + 1'b1;
         cursor_ff <= rd_end;
      end
      if (cmd.save_old) begin
         old_s_ff <= rd_start;
         old_e_ff <= rd_end;
         idx_ff   <= i_ff;
      end
      if (cmd.rsp_load) begin
         case (cmd.rsp_kind)
            ffba_pkg::RSP_OK: begin
               ok_ff   <= 1'b1;
               res_ff  <= '0;
               copy_ff <= '0;
            end
            ffba_pkg::RSP_BASE: begin
               ok_ff   <= 1'b1;
               res_ff  <= base_ff;
               copy_ff <= '0;
            end
            ffba_pkg::RSP_FIT: begin
               ok_ff   <= 1'b1;
               res_ff  <= base_ff + ffba_pkg::ADDR_W'(cursor_ff);
               copy_ff <= (op_ff == ffba_pkg::OP_RESIZE && present_ff)
                          ? ffba_pkg::SIZE_W'(copy_c) : '0;
            end
            default: begin
               ok_ff   <= 1'b0;
               res_ff  <= '0;
               copy_ff <= '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         psize_ff     <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we && csr_addr == ffba_pkg::CSR_POOL_BASE) begin
            base_ff <= csr_wdata;
         end
         if (csr_we && csr_addr == ffba_pkg::CSR_POOL_SIZE) begin
            psize_ff <= csr_wdata[OW-1:0];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, copy_ff, res_ff, ok_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_BLOCKS))
      else $error("block count beyond table depth");

   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      cmd.insert_new |-> !sts.full)
      else $error("insert into a full table");

   a_remove_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.remove |-> (i_ff < count_ff))
      else $error("remove outside the occupied table");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwrites an untaken item");

endmodule

`default_nettype wire

@@ sv/first_fit_block_allocator.sv @@
// top level of the first-fit block allocator
// instantiates ffba_ctrl and ffba_datapath; uses ffba_pkg
`timescale 1ns / 1ps
`default_nettype none

// First-fit allocator over one pool of up to 2**OFFSET_BITS bytes, keeping an
// address-sorted table of up to MAX_BLOCKS allocated blocks. One request item
// is worked on at a time: alloc walks the table one entry per clock from the
// lowest address, free walks it until the start address matches, resize walks
// to find the block and then walks again for the new place. Inserts and
// removals shift the whole table in parallel. The next item is taken as soon
// as the sequencer is back in idle, while a result may still sit in the
// output register waiting for rsp_tready. The user must write pool base and
// size through the csr port only while no item is in flight; the block itself
// does not enforce this.

module first_fit_block_allocator #(
   parameter int MAX_BLOCKS  = 16,
   parameter int OFFSET_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration writes: 0 pool_base, 1 pool_size
   input  wire logic                              csr_we,
   input  wire logic [ffba_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  wire logic [ffba_pkg::ADDR_W-1:0]       csr_wdata,
   // request items
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // block_address[31:0], request_size[48:32], zero pad
   input  wire logic [ffba_pkg::REQ_DATA_W-1:0]   req_tdata,
   // opcode[1:0], block_present[2]
   input  wire logic [ffba_pkg::REQ_USER_W-1:0]   req_tuser,
   // result items
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // success[0], result_address[32:1], copy_length[49:33], zero pad
   output logic [ffba_pkg::RSP_DATA_W-1:0]        rsp_tdata
);

   // command and status between sequencer and datapath
   ffba_pkg::cmd_type    cmd;
   ffba_pkg::status_type sts;

   ffba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // table, walk cursor, config registers and the output register
   ffba_datapath #(
      .MAX_BLOCKS  (MAX_BLOCKS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

`default_nettype wire

@@ tb/first_fit_block_allocator_test.sv @@
// self-checking testbench for first_fit_block_allocator
// predicts every result item with a first-fit table model; uses ffba_pkg
`timescale 1ns / 1ps

module first_fit_block_allocator_test;

   localparam int MAXB = 16;
   localparam int TAIL_CYCLES = 2 * MAXB + 20;

   typedef struct packed {
      logic        success;
      logic [31:0] address;
      logic [16:0] copy_len;
   } alloc_result_type;

   // allocation table predictor plus the queue of results still to arrive
   class alloc_scoreboard;
      logic [31:0]      base;
      logic [16:0]      size;
      logic [16:0]      starts[MAXB];
      logic [16:0]      ends[MAXB];
      int               count;
      alloc_result_type pending[$];
      int               errors;

      function new();
         base = 0; size = 0; count = 0; errors = 0;
      endfunction

      function void set_reg(ffba_pkg::csr_idx_type idx, logic [31:0] val);
         if (idx == ffba_pkg::CSR_POOL_BASE) base = val;
         else size = val[16:0];
      endfunction

      function void put(int pos, logic [16:0] s, logic [16:0] e);
         for (int i = count; i > pos; i--) begin
            starts[i] = starts[i-1];
            ends[i] = ends[i-1];
         end
         starts[pos] = s; ends[pos] = e; count++;
      endfunction

      function void drop(int pos);
         for (int i = pos; i < count - 1; i++) begin
            starts[i] = starts[i+1];
            ends[i] = ends[i+1];
         end
         count--;
      endfunction

      function int lookup(logic [31:0] a);
         for (int i = 0; i < count; i++)
            if (base + {15'd0, starts[i]} == a) return i;
         return -1;
      endfunction

      // first gap that fits; returns 1 and the absolute address on success
      function bit place(logic [16:0] sz, output logic [31:0] a);
         logic [16:0] cur;
         int pos;
         bit hit;
         cur = 0; pos = count; hit = 0; a = 0;
         if (sz > size) return 0;
         if (sz == 0) begin
            a = base;
            return 1;
         end
         if (count >= MAXB) return 0;
         for (int i = 0; i < count; i++) begin
            if (starts[i] >= cur && starts[i] - cur >= sz) begin
               pos = i; hit = 1;
               break;
            end
            cur = ends[i];
         end
         if (!hit && !(size >= cur && size - cur >= sz)) return 0;
         put(pos, cur, cur + sz);
         a = base + {15'd0, cur};
         return 1;
      endfunction

      function void note_request(ffba_pkg::opcode_type op, bit present, logic [31:0] a,
                                 logic [16:0] sz);
         alloc_result_type r;
         int idx;
         logic [16:0] s, e, old;
         r = '0;
         case (op)
            ffba_pkg::OP_ALLOC: begin
               r.success = place(sz, r.address);
            end
            ffba_pkg::OP_FREE: begin
               if (present) begin
                  idx = lookup(a);
                  if (idx >= 0) begin
                     drop(idx);
                     r.success = 1;
                  end
               end
            end
            ffba_pkg::OP_RESIZE: begin
               if (!present) begin
                  r.success = place(sz, r.address);
               end else begin
                  idx = lookup(a);
                  if (idx >= 0 && sz == 0) begin
                     drop(idx);
                  end else if (idx >= 0) begin
                     s = starts[idx]; e = ends[idx]; old = e - s;
                     drop(idx);
                     if (place(sz, r.address)) begin
                        r.success = 1;
                        r.copy_len = sz < old ? sz : old;
                     end else begin
                        r.address = 0;
                        put(idx, s, e);
                     end
                  end
               end
            end
            default: begin
               count = 0;
               r.success = 1;
            end
         endcase
         pending.push_back(r);
      endfunction

      function void check_result(logic [55:0] d);
         alloc_result_type want;
         if (pending.size() == 0) begin
            $error("unexpected result item %h", d);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (d[0] !== want.success) begin
            $error("success: expected %0d, got %0d", want.success, d[0]);
            errors++;
         end
         if (d[32:1] !== want.address) begin
            $error("result_address: expected %h, got %h", want.address, d[32:1]);
            errors++;
         end
         if (d[49:33] !== want.copy_len) begin
            $error("copy_length: expected %0d, got %0d", want.copy_len, d[49:33]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [ffba_pkg::CSR_IDX_W-1:0] csr_addr = '0;
   logic [31:0] csr_wdata = '0;
   logic req_tvalid = 0;
   logic req_tready;
   // block_address[31:0], request_size[48:32]
   logic [ffba_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   // opcode[1:0], block_present[2]
   logic [ffba_pkg::REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   // success[0], result_address[32:1], copy_length[49:33]
   logic [ffba_pkg::RSP_DATA_W-1:0] rsp_tdata;

   alloc_scoreboard sb = new();
   logic [31:0] live_addrs[$];   // addresses handed out, for well-formed frees
   bit sink_random = 1;

   first_fit_block_allocator u_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // result side: check each accepted item, then stall a random number of cycles
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_result(rsp_tdata);
         if (rsp_tdata[0] && rsp_tdata[32:1] != 0) live_addrs.push_back(rsp_tdata[32:1]);
         if (live_addrs.size() > 64) void'(live_addrs.pop_front());
         gap = sink_random ? $urandom_range(0, 14) : 0;
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   task automatic write_reg(ffba_pkg::csr_idx_type idx, logic [31:0] val);
      csr_we <= 1; csr_addr <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      sb.set_reg(idx, val);
   endtask

   // wait for every expected item, then let the block settle
   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic send(ffba_pkg::opcode_type op, bit present, logic [31:0] a,
                       logic [16:0] sz, bit idle_gap);
      int gap;
      gap = idle_gap ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {7'd0, sz, a};
      req_tuser <= {present, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, present, a, sz);
   endtask

   // mostly small sizes so the table fills; occasional large ones
   function automatic logic [16:0] pick_size();
      int k;
      k = $urandom_range(0, 19);
      if (k == 0) return 17'd0;
      if (k == 1) return 17'h10000;
      if (k < 4) return 17'($urandom_range(0, 17'h1ffff));
      return 17'($urandom_range(1, sb.size / 12 + 1));
   endfunction

   task automatic random_phase(int n, bit idle_gap);
      ffba_pkg::opcode_type op;
      logic [31:0] a;
      bit present;
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         present = 1;
         a = $urandom;
         if (k < 45) op = ffba_pkg::OP_ALLOC;
         else if (k < 70) op = ffba_pkg::OP_FREE;
         else if (k < 97) op = ffba_pkg::OP_RESIZE;
         else op = ffba_pkg::OP_CLEAR;
         if (live_addrs.size() > 0 && $urandom_range(0, 9) < 8)
            a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
         if ($urandom_range(0, 9) == 0) present = 0;
         if (op == ffba_pkg::OP_ALLOC) present = 1'($urandom_range(0, 1));
         send(op, present, a, pick_size(), idle_gap);
      end
      req_tvalid <= 0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty pool, zero-size, oversize, null handling
      send(ffba_pkg::OP_ALLOC, 0, 0, 0, 0);          // zero size with zero base
      send(ffba_pkg::OP_ALLOC, 0, 0, 1, 0);          // oversize on empty pool
      req_tvalid <= 0;
      drain();
      write_reg(ffba_pkg::CSR_POOL_BASE, 32'hffff_ff00);
      write_reg(ffba_pkg::CSR_POOL_SIZE, 32'h0001_0000);
      send(ffba_pkg::OP_ALLOC, 0, 0, 17'h10000, 0);  // whole pool
      send(ffba_pkg::OP_ALLOC, 1, 32'hffff_ffff, 1, 0); // full pool: no room
      send(ffba_pkg::OP_RESIZE, 1, 32'hffff_ff00, 17'h8000, 1); // shrink, copy shorter
      send(ffba_pkg::OP_ALLOC, 0, 0, 17'h10001, 0);  // beyond pool
      send(ffba_pkg::OP_FREE, 0, 32'hffff_ff00, 0, 0);  // null free
      send(ffba_pkg::OP_FREE, 1, 32'h1234_5678, 0, 0);  // unknown free
      send(ffba_pkg::OP_RESIZE, 1, 32'h1234_5678, 5, 0); // unknown resize
      send(ffba_pkg::OP_RESIZE, 0, 0, 16, 0);        // resize of null allocates
      send(ffba_pkg::OP_RESIZE, 1, 32'hffff_ff00, 0, 0); // resize to zero frees
      send(ffba_pkg::OP_FREE, 1, 32'hffff_ff00, 0, 0);   // already gone
      for (int i = 0; i < 17; i++) send(ffba_pkg::OP_ALLOC, 0, 0, 1, 1); // fill, then full
      send(ffba_pkg::OP_ALLOC, 0, 0, 0, 0);          // zero size while full
      send(ffba_pkg::OP_RESIZE, 1, 32'hffff_ff10, 17'h10000, 0); // unknown block: fails
      req_tvalid <= 0;
      // pool shrunk below the last block
      drain();
      write_reg(ffba_pkg::CSR_POOL_SIZE, 32'd8);
      send(ffba_pkg::OP_FREE, 1, 32'hffff_ff11, 0, 0);
      send(ffba_pkg::OP_ALLOC, 0, 0, 1, 0);
      send(ffba_pkg::OP_CLEAR, 0, 0, 0, 0);
      req_tvalid <= 0;

      // random phases over several pool settings, extremes included
      for (int ph = 0; ph < 7; ph++) begin
         drain();
         case (ph)
            0: begin
               write_reg(ffba_pkg::CSR_POOL_BASE, 32'd0);
               write_reg(ffba_pkg::CSR_POOL_SIZE, 32'h0001_0000);
            end
            1: begin
               write_reg(ffba_pkg::CSR_POOL_BASE, 32'hffff_ffff);
               write_reg(ffba_pkg::CSR_POOL_SIZE, 32'd0);
            end
            2: begin
               write_reg(ffba_pkg::CSR_POOL_BASE, $urandom);
               write_reg(ffba_pkg::CSR_POOL_SIZE, 32'd1);
            end
            default: begin
               write_reg(ffba_pkg::CSR_POOL_BASE, $urandom);
               write_reg(ffba_pkg::CSR_POOL_SIZE, $urandom_range(1, 17'h10000));
            end
         endcase
         sink_random = (ph != 4);
         random_phase(ph == 1 || ph == 2 ? 80 : 240, ph != 5);
      end

      drain();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
